// ===== design/frd_pkg.sv =====
// Shared constants, register codes and table functions for the fisheye ray core.
// No dependencies; the CORDIC cell, the top level, the checker and the testbench import this package.
package frd_pkg;

  localparam int PADDR_W     = 6;
  localparam int PDATA_W     = 64;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 72;

  // Register codes, taken from paddr[5:3]
  localparam logic [2:0] REG_MAX_HALF_ANGLE = 3'd0;
  localparam logic [2:0] REG_HORIZ_RES      = 3'd1;
  localparam logic [2:0] REG_VERT_RES       = 3'd2;
  localparam logic [2:0] REG_PIXEL_SIZE     = 3'd3;
  localparam logic [2:0] REG_BASIS_U        = 3'd4;
  localparam logic [2:0] REG_BASIS_V        = 3'd5;
  localparam logic [2:0] REG_BASIS_W        = 3'd6;

  // Angles in Q.23 degrees
  localparam logic [32:0] DEG360 = 33'd3019898880;
  localparam logic [31:0] DEG180 = 32'd1509949440;
  localparam logic [31:0] DEG90  = 32'd754974720;

  // Degrees to radians, a Q.39 constant for a Q.30 result, split for two narrow partial products
  localparam logic [33:0] RAD_MUL = 34'd9595049034;
  localparam logic [16:0] RAD_LO  = RAD_MUL[16:0];
  localparam logic [16:0] RAD_HI  = RAD_MUL[33:17];

  localparam int CORDIC_W = 33;
  localparam int ATAN_LEN = 24;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;

  function automatic logic [29:0] atan_q30(input int unsigned idx);
    case (idx)
      0:  atan_q30 = 30'd843314857;
      1:  atan_q30 = 30'd497837829;
      2:  atan_q30 = 30'd263043837;
      3:  atan_q30 = 30'd133525159;
      4:  atan_q30 = 30'd67021687;
      5:  atan_q30 = 30'd33543516;
      6:  atan_q30 = 30'd16775851;
      7:  atan_q30 = 30'd8388437;
      8:  atan_q30 = 30'd4194283;
      9:  atan_q30 = 30'd2097149;
      10: atan_q30 = 30'd1048575;
      11: atan_q30 = 30'd524288;
      12: atan_q30 = 30'd262144;
      13: atan_q30 = 30'd131072;
      14: atan_q30 = 30'd65536;
      15: atan_q30 = 30'd32768;
      16: atan_q30 = 30'd16384;
      17: atan_q30 = 30'd8192;
      18: atan_q30 = 30'd4096;
      19: atan_q30 = 30'd2048;
      20: atan_q30 = 30'd1024;
      21: atan_q30 = 30'd512;
      22: atan_q30 = 30'd256;
      23: atan_q30 = 30'd128;
      default: atan_q30 = 30'd0;
    endcase
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [22:0] v);
    if (v > 23'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -23'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

endpackage

// ===== design/frd_div_cell.sv =====
// One restoring-division cell: a trial subtract of the shifted divisor.
// Depends on frd_pkg only by convention; no package items are needed here.
module frd_div_cell #(
  parameter int NW    = 41,
  parameter int DW    = 29,
  parameter int QW    = 20,
  parameter int SHIFT = 0,
  parameter int TW    = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_rem,
  input  logic [QW-1:0] in_quo,
  input  logic [DW-1:0] in_den,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [NW-1:0] out_rem,
  output logic [QW-1:0] out_quo,
  output logic [DW-1:0] out_den,
  output logic [TW-1:0] out_tag
);
  localparam int CW = ((NW > DW + SHIFT) ? NW : DW + SHIFT) + 1;

  logic [CW-1:0] dsh;
  logic [CW-1:0] diff;
  logic          ge;

  assign dsh  = CW'(in_den) << SHIFT;
  assign diff = CW'(in_rem) - dsh;
  assign ge   = ~diff[CW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem <= ge ? diff[NW-1:0] : in_rem;
      out_quo <= in_quo | (QW'(ge) << SHIFT);
      out_den <= in_den;
      out_tag <= in_tag;
    end
  end

endmodule

// ===== design/frd_sqrt_cell.sv =====
// One digit-by-digit square root cell: decides result bit B.
// No package items are needed here.
module frd_sqrt_cell #(
  parameter int VW = 33,
  parameter int RW = 17,
  parameter int B  = 0,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [VW-1:0] in_rem,
  input  logic [RW-1:0] in_res,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [VW-1:0] out_rem,
  output logic [RW-1:0] out_res,
  output logic [TW-1:0] out_tag
);
  localparam int CW = VW + 2;

  logic [CW-1:0] trial;
  logic [CW-1:0] remx;
  logic [CW-1:0] diff;
  logic          ge;

  // (res + 2^B)^2 - res^2 = res*2^(B+1) + 2^(2B)
  assign trial = (CW'(in_res) << (B + 1)) + (CW'(1) << (2 * B));
  assign remx  = CW'(in_rem);
  assign ge    = remx >= trial;
  assign diff  = remx - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem <= ge ? diff[VW-1:0] : in_rem;
      out_res <= in_res | (RW'(ge) << B);
      out_tag <= in_tag;
    end
  end

endmodule

// ===== design/frd_cordic_cell.sv =====
// One rotation-mode CORDIC micro-rotation by atan(2^-I).
// Depends on frd_pkg for the angle table and the datapath width.
module frd_cordic_cell #(
  parameter int I  = 0,
  parameter int TW = 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [frd_pkg::CORDIC_W-1:0]   in_x,
  input  logic signed [frd_pkg::CORDIC_W-1:0]   in_y,
  input  logic signed [frd_pkg::CORDIC_W-1:0]   in_z,
  input  logic [TW-1:0]                         in_tag,
  output logic                                  out_valid,
  output logic signed [frd_pkg::CORDIC_W-1:0]   out_x,
  output logic signed [frd_pkg::CORDIC_W-1:0]   out_y,
  output logic signed [frd_pkg::CORDIC_W-1:0]   out_z,
  output logic [TW-1:0]                         out_tag
);
  import frd_pkg::*;

  logic signed [CORDIC_W-1:0] at;
  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;

  assign at = signed'(CORDIC_W'(atan_q30(I)));
  assign xs = in_x >>> I;
  assign ys = in_y >>> I;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!in_z[CORDIC_W-1]) begin
        out_x <= in_x - ys;
        out_y <= in_y + xs;
        out_z <= in_z - at;
      end else begin
        out_x <= in_x + ys;
        out_y <= in_y - xs;
        out_z <= in_z + at;
      end
      out_tag <= in_tag;
    end
  end

endmodule

// ===== design/fisheye_ray_direction_core.sv =====
// Top level of the fisheye ray core: config registers, cell chains, glue stages.
// Depends on frd_pkg, frd_div_cell, frd_sqrt_cell and frd_cordic_cell.
//
//  channel   dir   handshake                    contents
//  s_axis    in    tvalid/tready                word: plane_x, plane_y
//  m_axis    out   tvalid/tready                word: dir_x/y/z, radius_squared; tuser inside_disc
//  apb       in    psel/penable/pwrite/pready   seven config registers at 8*i
//
//  One word per cycle in and out while m_axis is not stalled; the path runs through
//  the two division chains (20 and 31 cells), the 17-cell square root chain and
//  the CORDIC chain.
//  Reset (rst, synchronous) clears the valid bits and loads register defaults.
//  A stall on m_axis freezes the whole chain; s_axis_tready drops with it.
module fisheye_ray_direction_core #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [frd_pkg::PADDR_W-1:0]       paddr,
  input  logic [frd_pkg::PDATA_W-1:0]       pwdata,
  output logic [frd_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // plane_x [23:0], plane_y [47:24]
  input  logic [frd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // dir_x [15:0], dir_y [31:16], dir_z [47:32], radius_squared [67:48], zero [71:68]
  output logic [frd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // inside_disc [0]
  output logic [0:0]                        m_axis_tuser
);
  import frd_pkg::*;

  localparam int NQW = 20;   // normalize quotient bits 19..0
  localparam int NNW = 41;   // |p| << 17
  localparam int NDW = 29;   // pixel_size * resolution
  localparam int SRW = 17;   // square root result bits
  localparam int SVW = 33;   // square root operand
  localparam int CQW = 31;   // cosine/sine quotient bits 30..0
  localparam int CNW = 49;   // |n| << 30

  typedef struct packed {
    logic signed [19:0] nx;
    logic signed [19:0] ny;
    logic [19:0]        r2;
    logic               in_disc;
  } sq_meta_t;

  typedef struct packed {
    logic [32:0] dang;
    logic        sx;
    logic [19:0] r2;
    logic        in_disc;
    logic        rzero;
  } ang_meta_t;

  typedef struct packed {
    logic signed [31:0] ca;
    logic signed [31:0] sa;
    logic [19:0]        r2;
    logic               in_disc;
    logic               rzero;
    logic               sneg;
    logic               cneg;
  } post_t;

  // ---------------- configuration registers ----------------
  logic [15:0] max_half_angle;
  logic [12:0] horiz_resolution;
  logic [12:0] vert_resolution;
  logic [15:0] pixel_size;
  logic [47:0] basis_u;
  logic [47:0] basis_v;
  logic [47:0] basis_w;
  logic [2:0]  reg_sel;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1:3];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_half_angle   <= 16'd23040;
      horiz_resolution <= 13'd640;
      vert_resolution  <= 13'd480;
      pixel_size       <= 16'd256;
      basis_u          <= 48'd16384;
      basis_v          <= 48'd1073741824;
      basis_w          <= 48'd70368744177664;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_MAX_HALF_ANGLE: max_half_angle   <= pwdata[15:0];
        REG_HORIZ_RES:      horiz_resolution <= pwdata[12:0];
        REG_VERT_RES:       vert_resolution  <= pwdata[12:0];
        REG_PIXEL_SIZE:     pixel_size       <= pwdata[15:0];
        REG_BASIS_U:        basis_u          <= pwdata[47:0];
        REG_BASIS_V:        basis_v          <= pwdata[47:0];
        REG_BASIS_W:        basis_w          <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MAX_HALF_ANGLE: prdata = PDATA_W'(max_half_angle);
      REG_HORIZ_RES:      prdata = PDATA_W'(horiz_resolution);
      REG_VERT_RES:       prdata = PDATA_W'(vert_resolution);
      REG_PIXEL_SIZE:     prdata = PDATA_W'(pixel_size);
      REG_BASIS_U:        prdata = PDATA_W'(basis_u);
      REG_BASIS_V:        prdata = PDATA_W'(basis_v);
      REG_BASIS_W:        prdata = PDATA_W'(basis_w);
      default:            prdata = '0;
    endcase
  end

  // Divisors are registered from the registers, following them in the next cycle; a zero register counts as one.
  logic [15:0]    size_eff;
  logic [12:0]    hres_eff;
  logic [12:0]    vres_eff;
  logic [NDW-1:0] den_h;
  logic [NDW-1:0] den_v;

  assign size_eff = (pixel_size == 16'd0) ? 16'd1 : pixel_size;
  assign hres_eff = (horiz_resolution == 13'd0) ? 13'd1 : horiz_resolution;
  assign vres_eff = (vert_resolution == 13'd0) ? 13'd1 : vert_resolution;

  always_ff @(posedge clk) begin
    den_h <= size_eff * hres_eff;
    den_v <= size_eff * vres_eff;
  end

  // Basis components, x in the low half-word
  logic signed [15:0] uc [3];
  logic signed [15:0] vc [3];
  logic signed [15:0] wc [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      uc[k] = signed'(basis_u[16*k +: 16]);
      vc[k] = signed'(basis_v[16*k +: 16]);
      wc[k] = signed'(basis_w[16*k +: 16]);
    end
  end

  // ---------------- flow control ----------------
  // The chain advances whenever the output register is free or being drained.
  logic en;
  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- input stage: sign and magnitude ----------------
  logic [23:0]    px;
  logic [23:0]    py;
  logic [23:0]    pmx;
  logic [23:0]    pmy;
  logic           s0_v;
  logic           s0_sx;
  logic           s0_sy;
  logic [NNW-1:0] s0_nx;
  logic [NNW-1:0] s0_ny;

  assign px  = s_axis_tdata[23:0];
  assign py  = s_axis_tdata[47:24];
  assign pmx = px[23] ? (~px + 24'd1) : px;
  assign pmy = py[23] ? (~py + 24'd1) : py;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_sx <= px[23];
      s0_sy <= py[23];
      s0_nx <= {pmx, 17'd0};
      s0_ny <= {pmy, 17'd0};
    end
  end

  // ---------------- normalize: two division chains ----------------
  // The top cell (bit 19) only flags a quotient far beyond the clamp.
  logic           nv   [NQW+1];
  logic           nvy  [NQW+1];
  logic [NNW-1:0] nxr  [NQW+1];
  logic [NNW-1:0] nyr  [NQW+1];
  logic [NQW-1:0] nxq  [NQW+1];
  logic [NQW-1:0] nyq  [NQW+1];
  logic [NDW-1:0] nxd  [NQW+1];
  logic [NDW-1:0] nyd  [NQW+1];
  logic [0:0]     nxt  [NQW+1];
  logic [0:0]     nyt  [NQW+1];

  assign nv[0]  = s0_v;
  assign nvy[0] = s0_v;
  assign nxr[0] = s0_nx;
  assign nyr[0] = s0_ny;
  assign nxq[0] = '0;
  assign nyq[0] = '0;
  assign nxd[0] = den_h;
  assign nyd[0] = den_v;
  assign nxt[0] = s0_sx;
  assign nyt[0] = s0_sy;

  for (genvar j = 0; j < NQW; j++) begin : g_norm
    frd_div_cell #(
      .NW(NNW), .DW(NDW), .QW(NQW), .SHIFT(NQW - 1 - j), .TW(1)
    ) u_dx (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(nv[j]), .in_rem(nxr[j]), .in_quo(nxq[j]), .in_den(nxd[j]),
      .in_tag(nxt[j]),
      .out_valid(nv[j+1]), .out_rem(nxr[j+1]), .out_quo(nxq[j+1]),
      .out_den(nxd[j+1]), .out_tag(nxt[j+1])
    );
    frd_div_cell #(
      .NW(NNW), .DW(NDW), .QW(NQW), .SHIFT(NQW - 1 - j), .TW(1)
    ) u_dy (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(nvy[j]), .in_rem(nyr[j]), .in_quo(nyq[j]), .in_den(nyd[j]),
      .in_tag(nyt[j]),
      .out_valid(nvy[j+1]), .out_rem(nyr[j+1]), .out_quo(nyq[j+1]),
      .out_den(nyd[j+1]), .out_tag(nyt[j+1])
    );
  end

  // Clamp to +-2^18 and restore the sign
  logic [18:0]        magx;
  logic [18:0]        magy;
  logic signed [19:0] nx_c;
  logic signed [19:0] ny_c;

  assign magx = (nxq[NQW] > 20'd262144) ? 19'd262144 : nxq[NQW][18:0];
  assign magy = (nyq[NQW] > 20'd262144) ? 19'd262144 : nyq[NQW][18:0];
  assign nx_c = nxt[NQW][0] ? -signed'({1'b0, magx}) : signed'({1'b0, magx});
  assign ny_c = nyt[NQW][0] ? -signed'({1'b0, magy}) : signed'({1'b0, magy});

  // ---------------- squares and radius ----------------
  logic               p1_v;
  logic signed [19:0] p1_nx;
  logic signed [19:0] p1_ny;
  logic               p2_v;
  logic signed [19:0] p2_nx;
  logic signed [19:0] p2_ny;
  logic [36:0]        p2_sqx;
  logic [36:0]        p2_sqy;
  logic signed [39:0] sqx_full;
  logic signed [39:0] sqy_full;
  logic [37:0]        sum;
  logic               p3_v;
  sq_meta_t           p3_meta;
  logic [SVW-1:0]     p3_sv;

  assign sqx_full = p1_nx * p1_nx;
  assign sqy_full = p1_ny * p1_ny;
  assign sum      = {1'b0, p2_sqx} + {1'b0, p2_sqy};

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
    end else if (en) begin
      p1_v <= nv[NQW];
      p2_v <= p1_v;
      p3_v <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_nx  <= nx_c;
      p1_ny  <= ny_c;
      p2_nx  <= p1_nx;
      p2_ny  <= p1_ny;
      p2_sqx <= sqx_full[36:0];
      p2_sqy <= sqy_full[36:0];
      p3_meta.nx      <= p2_nx;
      p3_meta.ny      <= p2_ny;
      // Saturate radius squared at the top of Q4.16
      p3_meta.r2      <= (sum[37:16] > 22'd1048575) ? 20'hFFFFF : sum[35:16];
      p3_meta.in_disc <= (sum <= 38'h1_0000_0000);
      // Outside the disc the root is never used; feed zero
      p3_sv           <= (sum <= 38'h1_0000_0000) ? sum[SVW-1:0] : '0;
    end
  end

  // ---------------- square root chain ----------------
  logic           sv_ [SRW+1];
  logic [SVW-1:0] srem [SRW+1];
  logic [SRW-1:0] sres [SRW+1];
  sq_meta_t       stag [SRW+1];

  assign sv_[0]  = p3_v;
  assign srem[0] = p3_sv;
  assign sres[0] = '0;
  assign stag[0] = p3_meta;

  for (genvar j = 0; j < SRW; j++) begin : g_sqrt
    frd_sqrt_cell #(
      .VW(SVW), .RW(SRW), .B(SRW - 1 - j), .TW($bits(sq_meta_t))
    ) u_sq (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(sv_[j]), .in_rem(srem[j]), .in_res(sres[j]), .in_tag(stag[j]),
      .out_valid(sv_[j+1]), .out_rem(srem[j+1]), .out_res(sres[j+1]),
      .out_tag(stag[j+1])
    );
  end

  // ---------------- angle product and cosine/sine numerators ----------------
  sq_meta_t       sq_out;
  logic [SRW-1:0] r_root;
  logic [19:0]    anx;
  logic [19:0]    any_;
  logic           q1_v;
  logic [SRW-1:0] q1_r;
  logic [CNW-1:0] q1_cx;
  logic [CNW-1:0] q1_cy;
  ang_meta_t      q1_meta;
  logic           q1_sy;

  assign sq_out = stag[SRW];
  assign r_root = sres[SRW];
  assign anx    = sq_out.nx[19] ? 20'(-sq_out.nx) : 20'(sq_out.nx);
  assign any_   = sq_out.ny[19] ? 20'(-sq_out.ny) : 20'(sq_out.ny);

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_v <= 1'b0;
    end else if (en) begin
      q1_v <= sv_[SRW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_r            <= r_root;
      q1_cx           <= {anx[18:0], 30'd0};
      q1_cy           <= {any_[18:0], 30'd0};
      q1_sy           <= sq_out.ny[19];
      q1_meta.dang    <= r_root * max_half_angle;
      q1_meta.sx      <= sq_out.nx[19];
      q1_meta.r2      <= sq_out.r2;
      q1_meta.in_disc <= sq_out.in_disc;
      q1_meta.rzero   <= (r_root == '0);
    end
  end

  // ---------------- cosine/sine of azimuth: two division chains ----------------
  logic           cv   [CQW+1];
  logic           cvy  [CQW+1];
  logic [CNW-1:0] cxr  [CQW+1];
  logic [CNW-1:0] cyr  [CQW+1];
  logic [CQW-1:0] cxq  [CQW+1];
  logic [CQW-1:0] cyq  [CQW+1];
  logic [SRW-1:0] cxd  [CQW+1];
  logic [SRW-1:0] cyd  [CQW+1];
  ang_meta_t      cxt  [CQW+1];
  logic [0:0]     cyt  [CQW+1];

  assign cv[0]  = q1_v;
  assign cvy[0] = q1_v;
  assign cxr[0] = q1_cx;
  assign cyr[0] = q1_cy;
  assign cxq[0] = '0;
  assign cyq[0] = '0;
  assign cxd[0] = q1_r;
  assign cyd[0] = q1_r;
  assign cxt[0] = q1_meta;
  assign cyt[0] = q1_sy;

  for (genvar j = 0; j < CQW; j++) begin : g_azim
    frd_div_cell #(
      .NW(CNW), .DW(SRW), .QW(CQW), .SHIFT(CQW - 1 - j), .TW($bits(ang_meta_t))
    ) u_cx (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(cv[j]), .in_rem(cxr[j]), .in_quo(cxq[j]), .in_den(cxd[j]),
      .in_tag(cxt[j]),
      .out_valid(cv[j+1]), .out_rem(cxr[j+1]), .out_quo(cxq[j+1]),
      .out_den(cxd[j+1]), .out_tag(cxt[j+1])
    );
    frd_div_cell #(
      .NW(CNW), .DW(SRW), .QW(CQW), .SHIFT(CQW - 1 - j), .TW(1)
    ) u_cy (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(cvy[j]), .in_rem(cyr[j]), .in_quo(cyq[j]), .in_den(cyd[j]),
      .in_tag(cyt[j]),
      .out_valid(cvy[j+1]), .out_rem(cyr[j+1]), .out_quo(cyq[j+1]),
      .out_den(cyd[j+1]), .out_tag(cyt[j+1])
    );
  end

  ang_meta_t          az_meta;
  logic signed [31:0] ca_c;
  logic signed [31:0] sa_c;

  assign az_meta = cxt[CQW];
  assign ca_c = az_meta.sx ? -signed'({1'b0, cxq[CQW]}) : signed'({1'b0, cxq[CQW]});
  assign sa_c = cyt[CQW][0] ? -signed'({1'b0, cyq[CQW]}) : signed'({1'b0, cyq[CQW]});

  // ---------------- angle reduction and radians ----------------
  logic        m1_v, m2_v, f1_v, f2_v, r1_v, r2_v;
  post_t       m1_p, m2_p, f1_p, f2_p, r1_p, r2_p;
  post_t       f1_p_next, f2_p_next;
  logic [32:0] m1_deg;
  logic [31:0] m2_deg;
  logic [31:0] f1_deg;
  logic [31:0] f1_deg_next;
  logic [29:0] f2_deg;
  logic [29:0] f2_deg_next;
  logic [46:0] r1_plo;
  logic [46:0] r1_phi;
  logic [64:0] rad_full;
  logic [31:0] r2_z;

  assign rad_full = {1'b0, r1_phi, 17'd0} + 65'(r1_plo);

  always_comb begin
    // Fold the lower half-turn: both sine and cosine flip
    f1_p_next   = m2_p;
    f1_deg_next = m2_deg;
    if (m2_deg > DEG180) begin
      f1_deg_next    = m2_deg - DEG180;
      f1_p_next.sneg = 1'b1;
      f1_p_next.cneg = 1'b1;
    end
    // Fold the second quadrant: cosine flips
    f2_p_next   = f1_p;
    f2_deg_next = f1_deg[29:0];
    if (f1_deg > DEG90) begin
      f2_deg_next    = 30'(DEG180 - f1_deg);
      f2_p_next.cneg = ~f1_p.cneg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
      m2_v <= 1'b0;
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      r1_v <= 1'b0;
      r2_v <= 1'b0;
    end else if (en) begin
      m1_v <= cv[CQW];
      m2_v <= m1_v;
      f1_v <= m2_v;
      f2_v <= f1_v;
      r1_v <= f2_v;
      r2_v <= r1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Reduce modulo 360 degrees: the product stays below three turns
      m1_deg    <= (az_meta.dang >= DEG360) ? az_meta.dang - DEG360 : az_meta.dang;
      m1_p.ca      <= ca_c;
      m1_p.sa      <= sa_c;
      m1_p.r2      <= az_meta.r2;
      m1_p.in_disc <= az_meta.in_disc;
      m1_p.rzero   <= az_meta.rzero;
      m1_p.sneg    <= 1'b0;
      m1_p.cneg    <= 1'b0;

      m2_deg <= (m1_deg >= DEG360) ? 32'(m1_deg - DEG360) : m1_deg[31:0];
      m2_p   <= m1_p;

      f1_p   <= f1_p_next;
      f1_deg <= f1_deg_next;

      f2_p   <= f2_p_next;
      f2_deg <= f2_deg_next;

      r1_plo <= f2_deg * RAD_LO;
      r1_phi <= f2_deg * RAD_HI;
      r1_p   <= f2_p;

      r2_z <= rad_full[63:32];
      r2_p <= r1_p;
    end
  end

  // ---------------- CORDIC chain ----------------
  logic                       kv [ANGLE_ITERATIONS+1];
  logic signed [CORDIC_W-1:0] kx [ANGLE_ITERATIONS+1];
  logic signed [CORDIC_W-1:0] ky [ANGLE_ITERATIONS+1];
  logic signed [CORDIC_W-1:0] kz [ANGLE_ITERATIONS+1];
  post_t                      kt [ANGLE_ITERATIONS+1];

  assign kv[0] = r2_v;
  assign kx[0] = CORDIC_GAIN;
  assign ky[0] = '0;
  assign kz[0] = signed'(CORDIC_W'(r2_z));
  assign kt[0] = r2_p;

  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cordic
    frd_cordic_cell #(.I(i), .TW($bits(post_t))) u_cr (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(kv[i]), .in_x(kx[i]), .in_y(ky[i]), .in_z(kz[i]), .in_tag(kt[i]),
      .out_valid(kv[i+1]), .out_x(kx[i+1]), .out_y(ky[i+1]), .out_z(kz[i+1]),
      .out_tag(kt[i+1])
    );
  end

  // ---------------- direction assembly ----------------
  post_t                      ck_p;
  logic                       c1_v, k1_v, k2_v;
  logic signed [CORDIC_W-1:0] c1_sin;
  logic signed [CORDIC_W-1:0] c1_cos;
  post_t                      c1_p, k1_p, k2_p;
  logic signed [64:0]         kc_full;
  logic signed [64:0]         ks_full;
  logic signed [34:0]         k1_kc;
  logic signed [34:0]         k1_ks;
  logic signed [CORDIC_W-1:0] k1_cos;
  logic signed [50:0]         k2_kcu [3];
  logic signed [50:0]         k2_ksv [3];
  logic signed [50:0]         k2_cw  [3];

  assign ck_p    = kt[ANGLE_ITERATIONS];
  assign kc_full = c1_sin * c1_p.ca;
  assign ks_full = c1_sin * c1_p.sa;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
      k1_v <= 1'b0;
      k2_v <= 1'b0;
    end else if (en) begin
      c1_v <= kv[ANGLE_ITERATIONS];
      k1_v <= c1_v;
      k2_v <= k1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_sin <= ck_p.sneg ? -ky[ANGLE_ITERATIONS] : ky[ANGLE_ITERATIONS];
      c1_cos <= ck_p.cneg ? -kx[ANGLE_ITERATIONS] : kx[ANGLE_ITERATIONS];
      c1_p   <= ck_p;

      // Floor by 2^30 is an arithmetic shift
      k1_kc  <= signed'(kc_full[64:30]);
      k1_ks  <= signed'(ks_full[64:30]);
      k1_cos <= c1_cos;
      k1_p   <= c1_p;

      for (int k = 0; k < 3; k++) begin
        k2_kcu[k] <= k1_kc * uc[k];
        k2_ksv[k] <= k1_ks * vc[k];
        k2_cw[k]  <= k1_cos * wc[k];
      end
      k2_p <= k1_p;
    end
  end

  logic signed [52:0] acc  [3];
  logic signed [22:0] wneg [3];
  logic signed [15:0] dfin [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k]  = 53'(k2_kcu[k]) + 53'(k2_ksv[k]) - 53'(k2_cw[k]) + (53'sd1 <<< 29);
      wneg[k] = -23'(wc[k]);
      if (!k2_p.in_disc) begin
        dfin[k] = '0;
      end else if (k2_p.rzero) begin
        // Center of the disc: the ray looks straight down -w
        dfin[k] = sat16(wneg[k]);
      end else begin
        dfin[k] = sat16(signed'(acc[k][52:30]));
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= k2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {4'd0, k2_p.r2, dfin[2], dfin[1], dfin[0]};
      m_axis_tuser <= k2_p.in_disc;
    end
  end

endmodule

// ===== design/frd_checker.sv =====
// Port-level checks for the fisheye ray core, bound to the top level.
// Depends on frd_pkg for port widths.
module frd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [frd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [0:0]                       m_axis_tuser
);
  import frd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[47:0] == 48'd0)
    else $error("direction not zero outside the disc");

  a_inside_radius: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[67:48] <= 20'd65536)
    else $error("inside flag with radius beyond one");

  a_ready_when_empty: assert property (@(posedge clk)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind fisheye_ray_direction_core frd_checker u_frd_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for fisheye_ray_direction_core: stream points in, check rays out.
// Depends on frd_pkg and the core; the expected rays come from a scoreboard class below.
module tb_top;
  import frd_pkg::*;

  localparam int ITERS = 16;
  localparam int RUN_LIMIT = 400000;

  // One expected ray per accepted point, held oldest first.
  class ray_scoreboard;
    typedef struct {
      logic [15:0] dx, dy, dz;
      logic [19:0] rsq;
      logic        in_disc;
    } ray_t;

    ray_t        pending[$];
    int          errors;
    logic [15:0] half_angle, pix;
    logic [12:0] hres, vres;
    logic [47:0] bas_u, bas_v, bas_w;
    longint      atan_q30[24] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
      8388437, 4194283, 2097149, 1048575, 524288, 262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048, 1024, 512, 256, 128};

    function new();
      errors = 0;
      half_angle = 16'd23040;
      hres = 13'd640;
      vres = 13'd480;
      pix = 16'd256;
      bas_u = 48'd16384;
      bas_v = 48'd1073741824;
      bas_w = 48'd70368744177664;
    endfunction

    function void store(logic [2:0] code, logic [63:0] val);
      case (code)
        REG_MAX_HALF_ANGLE: half_angle = val[15:0];
        REG_HORIZ_RES:      hres = val[12:0];
        REG_VERT_RES:       vres = val[12:0];
        REG_PIXEL_SIZE:     pix = val[15:0];
        REG_BASIS_U:        bas_u = val[47:0];
        REG_BASIS_V:        bas_v = val[47:0];
        REG_BASIS_W:        bas_w = val[47:0];
        default: ;
      endcase
    endfunction

    function longint scale_to_disc(longint p, longint sz, longint res);
      longint q;
      if (sz == 0) sz = 1;
      if (res == 0) res = 1;
      q = (p * 131072) / (sz * res);
      if (q > 262144) q = 262144;
      if (q < -262144) q = -262144;
      return q;
    endfunction

    function longint unsigned floor_root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 38;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // Fold the angle into the first quadrant, then rotate.
    function void sine_cosine(longint unsigned deg, output longint s, output longint c);
      longint unsigned d90, d180;
      longint x, y, z, tx, ty;
      bit sneg, cneg;
      d90 = 64'd90 << 23;
      d180 = 64'd180 << 23;
      sneg = 0;
      cneg = 0;
      x = 652032874;
      y = 0;
      deg = deg % (64'd360 << 23);
      if (deg > d180) begin
        deg -= d180;
        sneg = 1;
        cneg = 1;
      end
      if (deg > d90) begin
        deg = d180 - deg;
        cneg = !cneg;
      end
      z = longint'((deg * 64'd9595049034) >> 32);
      for (int i = 0; i < ITERS; i++) begin
        if (z >= 0) begin
          tx = x - (y >>> i);
          ty = y + (x >>> i);
          z -= atan_q30[i];
        end else begin
          tx = x + (y >>> i);
          ty = y - (x >>> i);
          z += atan_q30[i];
        end
        x = tx;
        y = ty;
      end
      s = sneg ? -y : y;
      c = cneg ? -x : x;
    endfunction

    function logic [15:0] clip16(longint v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return v[15:0];
    endfunction

    function void note(logic [23:0] px, logic [23:0] py);
      longint nx, ny, sum, r, sp, cp, ca, sa, kc, ks, acc, uc, vc, wc;
      logic [15:0] comp[3];
      ray_t e;
      nx = scale_to_disc(longint'($signed(px)), pix, hres);
      ny = scale_to_disc(longint'($signed(py)), pix, vres);
      sum = nx * nx + ny * ny;
      e.rsq = ((sum >> 16) > 1048575) ? 20'hfffff : sum[35:16];
      e.in_disc = (sum <= (64'sd1 << 32));
      comp = '{16'd0, 16'd0, 16'd0};
      if (e.in_disc) begin
        r = longint'(floor_root(sum));
        for (int k = 0; k < 3; k++) begin
          uc = longint'($signed(bas_u[16*k +: 16]));
          vc = longint'($signed(bas_v[16*k +: 16]));
          wc = longint'($signed(bas_w[16*k +: 16]));
          if (r == 0) begin
            // dead center: the ray is straight down -w
            comp[k] = clip16(-wc);
          end else begin
            sine_cosine(r * half_angle, sp, cp);
            ca = (nx * (64'sd1 << 30)) / r;
            sa = (ny * (64'sd1 << 30)) / r;
            kc = (sp * ca) >>> 30;
            ks = (sp * sa) >>> 30;
            acc = kc * uc + ks * vc - cp * wc + (64'sd1 << 29);
            comp[k] = clip16(acc >>> 30);
          end
        end
      end
      e.dx = comp[0];
      e.dy = comp[1];
      e.dz = comp[2];
      pending.push_back(e);
    endfunction

    function void check(logic [OUT_TDATA_W-1:0] d, logic u);
      ray_t e;
      if (pending.size() == 0) begin
        $error("ray word with nothing expected: %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.dx) begin
        $error("dir_x expected %0d got %0d", $signed(e.dx), $signed(d[15:0]));
        errors++;
      end
      if (d[31:16] !== e.dy) begin
        $error("dir_y expected %0d got %0d", $signed(e.dy), $signed(d[31:16]));
        errors++;
      end
      if (d[47:32] !== e.dz) begin
        $error("dir_z expected %0d got %0d", $signed(e.dz), $signed(d[47:32]));
        errors++;
      end
      if (d[67:48] !== e.rsq) begin
        $error("radius_squared expected %0d got %0d", e.rsq, d[67:48]);
        errors++;
      end
      if (u !== e.in_disc) begin
        $error("inside_disc expected %0d got %0d", e.in_disc, u);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_W-1:0]     paddr = '0;
  logic [PDATA_W-1:0]     pwdata = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;

  ray_scoreboard sb = new();
  int sent = 0;
  int got = 0;
  int cycles = 0;

  fisheye_ray_direction_core #(.ANGLE_ITERATIONS(ITERS)) u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung pipe or a lost word ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Register write with a setup and an access phase; the register loads at the access edge.
  task automatic reg_write(logic [2:0] code, logic [63:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {code, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.store(code, val);
  endtask

  // Offer one point; idle first at random except in the calm stretch.
  task automatic send_point(logic [23:0] x, logic [23:0] y);
    while ($urandom_range(99) < 32 && !(sent >= 500 && sent < 700)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {y, x};
    do @(posedge clk); while (!s_axis_tready);
    sb.note(x, y);
    sent++;
  endtask

  // Hold configuration changes until every ray is back and the pipe is empty.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Disc half-width in input units, so most points land near the disc.
  function automatic int unsigned disc_span(logic [15:0] sz, logic [12:0] res);
    longint s;
    s = longint'(sz == 0 ? 1 : sz) * longint'(res == 0 ? 1 : res) / 2;
    if (s < 1) s = 1;
    if (s > 8388607) s = 8388607;
    return int'(s);
  endfunction

  function automatic logic [23:0] pick(int unsigned span);
    int v;
    if ($urandom_range(99) < 75) begin
      v = int'($urandom_range(2 * span)) - int'(span);
    end else begin
      v = int'($urandom);
    end
    return v[23:0];
  endfunction

  task automatic random_points(int n);
    int unsigned sx, sy;
    sx = disc_span(sb.pix, sb.hres);
    sy = disc_span(sb.pix, sb.vres);
    repeat (n) send_point(pick(sx), pick(sy));
  endtask

  task automatic random_basis();
    reg_write(REG_BASIS_U, {$urandom, $urandom});
    reg_write(REG_BASIS_V, {$urandom, $urandom});
    reg_write(REG_BASIS_W, {$urandom, $urandom});
  endtask

  // Result side: random back-pressure, one long hold to fill the pipe.
  initial begin
    bit held;
    held = 0;
    @(negedge rst);
    forever begin
      if (!held && got >= 300) begin
        held = 1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      m_axis_tready <= ($urandom_range(99) >= 32) || (got >= 500 && got < 700);
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check(m_axis_tdata, m_axis_tuser[0]);
        got++;
      end
    end
  end

  initial begin
    int unsigned sx, sy;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Defaults, written explicitly; directed points around the disc.
    reg_write(REG_MAX_HALF_ANGLE, 64'd23040);
    reg_write(REG_HORIZ_RES, 64'd640);
    reg_write(REG_VERT_RES, 64'd480);
    reg_write(REG_PIXEL_SIZE, 64'd256);
    sx = disc_span(sb.pix, sb.hres);
    sy = disc_span(sb.pix, sb.vres);
    send_point(24'd0, 24'd0);
    send_point(24'(sx), 24'd0);
    send_point(24'(sx + 1), 24'd0);
    send_point(24'(sx + 2000), 24'd0);
    send_point(24'(-sx), 24'd0);
    send_point(24'd0, 24'(sy));
    send_point(24'd0, 24'(-sy));
    send_point(24'h7fffff, 24'h7fffff);
    send_point(24'h800000, 24'h800000);
    send_point(24'h7fffff, 24'h800000);
    send_point(24'(sx / 2), 24'(sy / 2));
    send_point(24'(-(sx / 3)), 24'(sy / 5));
    send_point(24'd1, 24'd0);
    send_point(24'd0, 24'd1);
    send_point(24'hffffff, 24'hffffff);
    random_points(185);
    drain();

    // Widest angle, wide flat plane, smallest pixel.
    reg_write(REG_MAX_HALF_ANGLE, 64'd46080);
    reg_write(REG_HORIZ_RES, 64'd4096);
    reg_write(REG_VERT_RES, 64'd1);
    reg_write(REG_PIXEL_SIZE, 64'd1);
    random_basis();
    random_points(200);
    drain();

    // Zero angle, largest pixel.
    reg_write(REG_MAX_HALF_ANGLE, 64'd0);
    reg_write(REG_HORIZ_RES, 64'd1);
    reg_write(REG_VERT_RES, 64'd4096);
    reg_write(REG_PIXEL_SIZE, 64'd65535);
    random_points(200);
    drain();

    // Zero size and resolution fall back to one; angle beyond a full turn wraps.
    reg_write(REG_MAX_HALF_ANGLE, 64'd65535);
    reg_write(REG_HORIZ_RES, 64'd0);
    reg_write(REG_VERT_RES, 64'd0);
    reg_write(REG_PIXEL_SIZE, 64'd0);
    reg_write(REG_BASIS_U, 64'h7fff_8000_7fff);
    reg_write(REG_BASIS_V, 64'h8000_7fff_8000);
    reg_write(REG_BASIS_W, 64'h8000_8000_8000);
    send_point(24'd0, 24'd0);
    random_points(200);
    drain();

    // Random settings inside the legal ranges.
    repeat (2) begin
      reg_write(REG_MAX_HALF_ANGLE, 64'($urandom_range(46080)));
      reg_write(REG_HORIZ_RES, 64'($urandom_range(4096, 1)));
      reg_write(REG_VERT_RES, 64'($urandom_range(4096, 1)));
      reg_write(REG_PIXEL_SIZE, 64'($urandom_range(65535, 1)));
      random_basis();
      random_points(200);
      drain();
    end

    // Back to the stock camera with a random frame.
    reg_write(REG_MAX_HALF_ANGLE, 64'd23040);
    reg_write(REG_HORIZ_RES, 64'd640);
    reg_write(REG_VERT_RES, 64'd480);
    reg_write(REG_PIXEL_SIZE, 64'd256);
    random_basis();
    random_points(200);
    drain();

    repeat (120) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
